// ===== rtl/psp_pkg.sv =====
// Shared types and constants for the perspective sprite projector.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package psp_pkg;

  // Sprite geometry
  localparam int SPRITE_SIDE   = 32;
  localparam int BYTES_PER_ROW = SPRITE_SIDE / 2;
  localparam int TOTAL_BYTES   = SPRITE_SIDE * SPRITE_SIDE / 2;
  localparam int POS_W         = $clog2(TOTAL_BYTES);
  localparam int COL_W         = $clog2(BYTES_PER_ROW);

  // Sprite coordinates in Q2.14
  localparam int COORD_STEP  = 32768 / SPRITE_SIDE;
  localparam int COORD_START = -16384;
  localparam int COORD_W     = 18;
  localparam int SUM_W       = COORD_W + 1;

  // Projection constants
  localparam int UNIT_SHIFT = 14;
  localparam int DIV_STEPS  = 32;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam logic [7:0] CENTER_X = 8'd160;
  localparam logic [7:0] CENTER_Y = 8'd120;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_DEPTH_Z  = 2'd2;
  localparam logic [15:0] DEPTH_RESET = 16'h4000;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] depth_z;
  } cfg_t;

  // One visible pixel waiting for projection
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [3:0]              color;
    logic                    last;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/psp_front.sv =====
// Front end: accepts sprite bytes, tracks the sprite position and emits one
// queue entry per visible pixel. Depends on psp_pkg.
`default_nettype none

module psp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire psp_pkg::cfg_t  cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     sprite_byte_i,
  output logic                push_o,
  output psp_pkg::pix_t       push_data_o,
  input  wire logic           full_i
);

  localparam logic signed [psp_pkg::COORD_W-1:0] START =
    psp_pkg::COORD_W'(psp_pkg::COORD_START);
  localparam logic signed [psp_pkg::COORD_W-1:0] STEP =
    psp_pkg::COORD_W'(psp_pkg::COORD_STEP);
  localparam logic signed [psp_pkg::COORD_W-1:0] STEP2 =
    psp_pkg::COORD_W'(2 * psp_pkg::COORD_STEP);

  logic [psp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [psp_pkg::COL_W-1:0] col_q, col_d;
  logic signed [psp_pkg::COORD_W-1:0] xbase_q, xbase_d, ycoord_q, ycoord_d;
  logic signed [psp_pkg::COORD_W-1:0] lat_x_q, lat_y_q;
  logic [7:0] byte_q;
  logic [1:0] pend_q, pend_d;
  logic       accept;
  logic       sel;
  logic signed [psp_pkg::COORD_W-1:0] xcoord;

  assign in_stall_o = |pend_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Pick the leftmost pending pixel and form its offset sums
  always_comb begin
    sel    = !pend_q[0];
    xcoord = lat_x_q + (sel ? STEP : '0);
    push_o = (|pend_q) && !full_i;
    push_data_o.sum_x = psp_pkg::SUM_W'(xcoord) + psp_pkg::SUM_W'(cfg_i.offset_x);
    push_data_o.sum_y = psp_pkg::SUM_W'(lat_y_q) + psp_pkg::SUM_W'(cfg_i.offset_y);
    push_data_o.color = sel ? byte_q[7:4] : byte_q[3:0];
    push_data_o.last  = sel ? 1'b1 : !pend_q[1];
  end

  // Advance position counters and pending mask
  always_comb begin
    pos_d    = pos_q;
    col_d    = col_q;
    xbase_d  = xbase_q;
    ycoord_d = ycoord_q;
    pend_d   = pend_q;
    if (push_o) begin
      pend_d[sel] = 1'b0;
    end
    if (accept) begin
      pend_d[0] = (sprite_byte_i[3:0] != 4'd0) && (cfg_i.depth_z != '0);
      pend_d[1] = (sprite_byte_i[7:4] != 4'd0) && (cfg_i.depth_z != '0);
      if (pos_q == psp_pkg::POS_W'(psp_pkg::TOTAL_BYTES - 1)) begin
        pos_d    = '0;
        col_d    = '0;
        xbase_d  = START;
        ycoord_d = START;
      end else begin
        pos_d = pos_q + 1'b1;
        if (col_q == psp_pkg::COL_W'(psp_pkg::BYTES_PER_ROW - 1)) begin
          col_d    = '0;
          xbase_d  = START;
          ycoord_d = ycoord_q + STEP;
        end else begin
          col_d   = col_q + 1'b1;
          xbase_d = xbase_q + STEP2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      col_q    <= '0;
      xbase_q  <= START;
      ycoord_q <= START;
      pend_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      col_q    <= col_d;
      xbase_q  <= xbase_d;
      ycoord_q <= ycoord_d;
      pend_q   <= pend_d;
    end
  end

  // Hold the accepted byte and its coordinates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= sprite_byte_i;
      lat_x_q <= xbase_q;
      lat_y_q <= ycoord_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psp_queue.sv =====
// Short pixel queue between the front end and the projection back end.
// Depends on psp_pkg for the entry type and depth.
`default_nettype none

module psp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire psp_pkg::pix_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output psp_pkg::pix_t      pop_data_o,
  output logic               empty_o
);

  psp_pkg::pix_t mem_q [psp_pkg::QUEUE_DEPTH];
  logic [psp_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [psp_pkg::QPTR_W:0]   cnt_q;

  assign full_o     = cnt_q == (psp_pkg::QPTR_W + 1)'(psp_pkg::QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psp_back.sv =====
// Back end: projects queued pixels through a shared bit-serial divider and
// holds each result in an output register. Depends on psp_pkg.
`default_nettype none

module psp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire psp_pkg::cfg_t cfg_i,
  input  wire logic          empty_i,
  input  wire psp_pkg::pix_t pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         screen_x_o,
  output logic [7:0]         screen_y_o,
  output logic [3:0]         color_o,
  output logic               last_of_byte_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  // Magnitude of a sum scaled by one in Q2.14
  function automatic logic [31:0] scaled_mag(logic signed [psp_pkg::SUM_W-1:0] s);
    logic [psp_pkg::SUM_W-1:0] m;
    m = s[psp_pkg::SUM_W-1] ? psp_pkg::SUM_W'(-s) : psp_pkg::SUM_W'(s);
    return {m[31-psp_pkg::UNIT_SHIFT:0], {psp_pkg::UNIT_SHIFT{1'b0}}};
  endfunction

  // Sign the low quotient bits, divide by 1024 toward zero, add center
  function automatic logic [7:0] to_screen(logic [15:0] qmag, logic neg,
                                           logic [7:0] center);
    logic [15:0]        k;
    logic signed [16:0] adj;
    k   = neg ? (~qmag + 16'd1) : qmag;
    adj = $signed({k[15], k}) + (k[15] ? 17'sd1023 : 17'sd0);
    return center + {adj[16], adj[16:10]};
  endfunction

  logic [1:0]  state_q, state_d;
  logic        axis_q;
  logic [psp_pkg::CNT_W-1:0] cnt_q;
  logic [31:0] num_q, num_nx;
  logic [15:0] rem_q, rem_nx;
  logic [16:0] rem_sh;
  logic        neg_q, ge;
  logic [15:0] dvs;
  logic [7:0]  sx_q, sy_q, scr;
  logic        last_step, out_take, out_load;
  psp_pkg::pix_t job_q;

  assign dvs = cfg_i.depth_z[15] ? 16'(-cfg_i.depth_z) : cfg_i.depth_z;

  // One restoring division step; the remainder stays below the divisor
  always_comb begin
    rem_sh = {rem_q, num_q[31]};
    ge     = rem_sh >= {1'b0, dvs};
    rem_nx = ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
    num_nx = {num_q[30:0], ge};
    scr    = to_screen(num_nx[15:0], neg_q, axis_q ? psp_pkg::CENTER_Y : psp_pkg::CENTER_X);
  end

  assign last_step = (state_q == S_DIV) && (cnt_q == psp_pkg::CNT_W'(psp_pkg::DIV_STEPS - 1));
  assign out_take  = out_valid_o && !out_stall_i;
  assign out_load  = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);
  assign pop_o     = (state_q == S_IDLE) && !empty_i;

  // Sequence: fetch pixel, divide x, divide y, deliver
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (pop_o) state_d = S_DIV;
      S_DIV:  if (last_step && axis_q) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        axis_q <= 1'b0;
        cnt_q  <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          axis_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_take) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Divider datapath and results
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= pop_data_i;
      num_q <= scaled_mag(pop_data_i.sum_x);
      rem_q <= '0;
      neg_q <= pop_data_i.sum_x[psp_pkg::SUM_W-1] ^ cfg_i.depth_z[15];
    end else if (state_q == S_DIV) begin
      if (last_step && !axis_q) begin
        sx_q  <= scr;
        num_q <= scaled_mag(job_q.sum_y);
        rem_q <= '0;
        neg_q <= job_q.sum_y[psp_pkg::SUM_W-1] ^ cfg_i.depth_z[15];
      end else begin
        num_q <= num_nx;
        rem_q <= rem_nx;
        if (last_step) begin
          sy_q <= scr;
        end
      end
    end
    if (out_load) begin
      screen_x_o     <= sx_q;
      screen_y_o     <= sy_q;
      color_o        <= job_q.color;
      last_of_byte_o <= job_q.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/perspective_sprite_projector.sv =====
// Perspective sprite projector top level: configuration registers, front end,
// pixel queue and projection back end. Depends on psp_pkg and its modules.
// Path of a visible pixel taken with the back end idle: push, queue read, two
// 32-step divisions, output register.
// The shared divider handles one visible pixel at a time; a byte with no
// visible pixel, or any byte at zero depth, does not stall the input.
// Reset: offsets clear to zero, depth to 1.0, position to the sprite start.
`default_nettype none

module perspective_sprite_projector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  sprite_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       screen_x_o,
  output logic [7:0]       screen_y_o,
  output logic [3:0]       color_o,
  output logic             last_of_byte_o
);

  psp_pkg::cfg_t cfg_q;
  psp_pkg::pix_t push_data, pop_data;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.depth_z  <= psp_pkg::DEPTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        psp_pkg::CFG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        psp_pkg::CFG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        psp_pkg::CFG_DEPTH_Z:  cfg_q.depth_z  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sprite_byte_i (sprite_byte_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  psp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  psp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .color_o        (color_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule

`default_nettype wire

// ===== sim/perspective_sprite_projector_tb.sv =====
// Self-checking testbench for perspective_sprite_projector: predicts every projected
// pixel of each sprite byte and compares it with what the block emits.
// Depends on psp_pkg and the perspective_sprite_projector RTL.

module perspective_sprite_projector_tb;
  import psp_pkg::*;

  localparam int UNIT_Q14      = 1 << UNIT_SHIFT;
  localparam int SCREEN_DIV    = 1024;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 112;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] color;
    logic       last;
  } screen_pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  sprite_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  screen_x_o;
  logic [7:0]  screen_y_o;
  logic [3:0]  color_o;
  logic        last_of_byte_o;

  // Bytes waiting to be offered, pixels waiting to be seen
  logic [7:0]    pending_bytes[$];
  screen_pixel_t expected_pixels[$];

  // Predictor state: register copies and position inside the sprite
  cfg_t proj_cfg = '{offset_x: 16'sd0, offset_y: 16'sd0, depth_z: DEPTH_RESET};
  int   sprite_pos = 0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   fail_count = 0;
  logic in_taken = 1'b0;
  int   hold_left = 0;
  logic hold_armed = 1'b0;
  logic hold_used = 1'b0;

  perspective_sprite_projector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sprite_byte_i  (sprite_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .color_o        (color_o),
    .last_of_byte_o (last_of_byte_o)
  );

  always #6 clk_i = ~clk_i;

  // Project one sprite coordinate onto its screen axis
  function automatic logic [7:0] screen_coord(input int coord, input int offset,
                                              input int depth, input logic [7:0] center);
    int                 scaled;
    int                 quotient;
    logic signed [15:0] wrapped;
    int                 shift;
    scaled   = (coord + offset) * UNIT_Q14;
    quotient = scaled / depth;
    wrapped  = quotient[15:0];
    shift    = wrapped / SCREEN_DIV;
    return center + shift[7:0];
  endfunction

  // Queue the pixels of one byte and advance the sprite position
  task automatic project_byte(input logic [7:0] pixel_pair);
    int            row;
    int            col;
    int            ycoord;
    logic [3:0]    colors[2];
    screen_pixel_t px;
    row       = sprite_pos / BYTES_PER_ROW;
    col       = sprite_pos % BYTES_PER_ROW;
    ycoord    = COORD_START + row * COORD_STEP;
    colors[0] = pixel_pair[3:0];
    colors[1] = pixel_pair[7:4];
    sprite_pos = (sprite_pos + 1) % TOTAL_BYTES;
    if (proj_cfg.depth_z == 0) return;
    for (int i = 0; i < 2; i++) begin
      if (colors[i] != 4'h0) begin
        px.x     = screen_coord(COORD_START + (col * 2 + i) * COORD_STEP,
                                proj_cfg.offset_x, proj_cfg.depth_z, CENTER_X);
        px.y     = screen_coord(ycoord, proj_cfg.offset_y, proj_cfg.depth_z, CENTER_Y);
        px.color = colors[i];
        px.last  = (i == 1) || (colors[1] == 4'h0);
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic report_failure(input logic had_due, input screen_pixel_t due,
                                input screen_pixel_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      if (had_due)
        $display({"%0t: pixel mismatch: expected x=%0d y=%0d color=%0d last=%0d,",
                  " got x=%0d y=%0d color=%0d last=%0d"},
                 $realtime, due.x, due.y, due.color, due.last,
                 seen.x, seen.y, seen.color, seen.last);
      else
        $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                 $realtime, seen.x, seen.y, seen.color, seen.last);
    end
  endtask

  // Predict on each accepted byte, check each accepted pixel
  always @(posedge clk_i) begin : monitor
    screen_pixel_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) project_byte(sprite_byte_i);
      if (out_valid_o && !out_stall_i) begin
        seen = {screen_x_o, screen_y_o, color_o, last_of_byte_o};
        if (expected_pixels.size() == 0) report_failure(1'b0, seen, seen);
        else if (seen !== expected_pixels[0]) report_failure(1'b1, expected_pixels[0], seen);
        if (expected_pixels.size() != 0) void'(expected_pixels.pop_front());
      end
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // Offer the next byte once the current one is taken; hold it while stalled
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i    <= 1'b1;
        sprite_byte_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off once armed
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OFFSET_X: proj_cfg.offset_x = data;
      CFG_OFFSET_Y: proj_cfg.offset_y = data;
      CFG_DEPTH_Z:  proj_cfg.depth_z  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_projection(input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] dz);
    write_register(CFG_OFFSET_X, ox);
    write_register(CFG_OFFSET_Y, oy);
    write_register(CFG_DEPTH_Z, dz);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 88; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Hold until every byte is taken and every pixel seen, then let the pipe settle
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_offset();
    logic [15:0] v;
    v = 16'($urandom_range(16383));
    if ($urandom_range(3) == 0) return 16'($urandom);
    return v - 16'd8192;
  endfunction

  function automatic logic [7:0] random_sprite_byte();
    logic [7:0] b;
    b = 8'($urandom);
    // bias toward transparent pixels now and then
    case ($urandom_range(9))
      0:       b = 8'h00;
      1, 2:    b[7:4] = 4'h0;
      3, 4:    b[3:0] = 4'h0;
      default: ;
    endcase
    return b;
  endfunction

  initial begin : stimulus
    logic [7:0]  plain_bytes[12] = '{8'h00, 8'h0F, 8'hF0, 8'hFF, 8'h01, 8'h10,
                                     8'h11, 8'h88, 8'hA5, 8'h5A, 8'h7E, 8'hE7};
    logic [15:0] dz;
    int          n;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset projection, transparent and full bytes
    set_idling(IDLE_NONE);
    foreach (plain_bytes[i]) pending_bytes.push_back(plain_bytes[i]);
    wait_idle();

    // Out-of-range register index must change nothing
    write_register(CFG_UNUSED, 16'hA5A5);
    write_register(CFG_UNUSED, 16'h5A5A);
    pending_bytes.push_back(8'h21);
    wait_idle();

    // Zero depth: nothing emitted, position still advances
    set_projection(16'h0000, 16'h0000, 16'h0000);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h12);
    wait_idle();

    // Smallest positive depth with extreme offsets: quotient and screen both wrap
    set_projection(16'h7FFF, 16'h8000, 16'h0001);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h3C);
    pending_bytes.push_back(8'hC3);
    wait_idle();

    // Most negative depth, opposite extreme offsets
    set_projection(16'h8000, 16'h7FFF, 16'h8000);
    pending_bytes.push_back(8'h99);
    pending_bytes.push_back(8'hFF);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering
    set_projection(16'h0000, 16'h0000, 16'h4000);
    set_idling(IDLE_NONE);
    hold_armed = 1'b1;
    repeat (60)
      pending_bytes.push_back({4'($urandom_range(15, 1)), 4'($urandom_range(15, 1))});
    wait_idle();

    // Random phases over a spread of projections and idling patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      n = PHASE_ITEMS;
      dz = 16'($urandom_range(28671) + 4096);
      if ($urandom_range(1) == 1) dz = -dz;
      if ($urandom_range(3) == 0) dz = 16'($urandom);
      case (p)
        0:       set_projection(16'h0000, 16'h0000, 16'h4000);
        1:       set_projection(16'h7FFF, 16'h8000, 16'h0001);
        2:       set_projection(16'h8000, 16'h7FFF, 16'hFFFF);
        3:       set_projection(random_offset(), random_offset(), 16'h7FFF);
        4:       set_projection(random_offset(), random_offset(), 16'h8000);
        5: begin
          set_projection(random_offset(), random_offset(), 16'h0000);
          n = 40;
        end
        6:       set_projection(16'h4000, 16'hC000, 16'h2000);
        default: set_projection(random_offset(), random_offset(), dz);
      endcase
      if (p % 3 == 0) write_register(CFG_UNUSED, 16'($urandom));
      set_idling(idle_mode_e'(p % 4));
      repeat (n) pending_bytes.push_back(random_sprite_byte());
      wait_idle();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Give up on a hung run
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
